// File: rtl/scm_pkg.sv
// Shared types and constants of the spatial channel mixer.
`timescale 1ns / 1ps
package scm_pkg;

    // Configuration register width and register indexes
    localparam int CFG_W         = 6;
    localparam int CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 1'b1;

    // Item opcodes
    localparam logic OPC_SAMPLE = 1'b0;
    localparam logic OPC_COEF   = 1'b1;

    // Fixed field widths
    localparam int CHAN_W    = 5;
    localparam int COEF_W    = 16;
    localparam int OUT_VAL_W = 32;
    localparam int OUT_TD_W  = ((CHAN_W + OUT_VAL_W + 7) / 8) * 8;

    typedef logic [CHAN_W-1:0]        t_chan;
    typedef logic signed [COEF_W-1:0] t_coef;

    // Control token that travels with a weight read down the MAC pipeline
    typedef struct packed {
        logic vld;   // a ring shift is due when this token comes out
        logic gate;  // channel is active; a closed gate adds zero
    } t_mac_ctl;

endpackage

// File: rtl/spatial_channel_mixer.sv
// Top level of the spatial channel mixer: weighted sum of input channels per output.
//
//  channel  | direction | tdata (low bit up)                          | tuser  | tlast
//  s_axis   | in        | sample_value, coef_row, coef_col, coef_value | opcode | -
//  m_axis   | out       | out_channel, out_value                       | -      | last
//  cfg      | in        | i_cfg_we / i_cfg_idx / i_cfg_data: num_inputs, num_outputs
//
// A sample rotates the accumulators once around a ring of MAX_OUT_CHANNELS cells past one
// shared MAC, which reads one weight a cycle from the weight table (one write port, one
// registered read port); no new item is taken until the rotation ends.
// After the last input channel the ring rotates once more to emit the results;
// a stalled output stops the rotation.
// Reset (synchronous) clears the accumulators, channel count and registers to 1;
// the weight table holds no reset value.
`timescale 1ns / 1ps
module spatial_channel_mixer #(
    parameter int MAX_IN_CHANNELS  = 32,
    parameter int MAX_OUT_CHANNELS = 32,
    parameter int SAMPLE_BITS      = 24,
    parameter int COEF_FRAC_BITS   = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [scm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [scm_pkg::CFG_W-1:0]             i_cfg_data,
    // input items
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_value, coef_row, coef_col, coef_value
    input  logic [((SAMPLE_BITS+2*scm_pkg::CHAN_W+scm_pkg::COEF_W+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic                                  s_axis_tuser,
    // result items
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_channel, out_value
    output logic [scm_pkg::OUT_TD_W-1:0]          m_axis_tdata,
    output logic                                  m_axis_tlast
);

    localparam int IN_W    = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int OUT_W   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int NI_W    = $clog2(MAX_IN_CHANNELS + 1);
    localparam int NO_W    = $clog2(MAX_OUT_CHANNELS + 1);
    localparam int STEP_W  = $clog2(MAX_OUT_CHANNELS + 2);
    localparam int SUM_W   = SAMPLE_BITS + scm_pkg::COEF_W + $clog2(MAX_IN_CHANNELS) + 1;
    localparam int ACC_W   = (SUM_W > scm_pkg::OUT_VAL_W + 1) ? SUM_W : scm_pkg::OUT_VAL_W + 1;
    localparam int AW      = OUT_W + IN_W;
    localparam int ROW_LSB = SAMPLE_BITS;
    localparam int COL_LSB = ROW_LSB + scm_pkg::CHAN_W;
    localparam int CF_LSB  = COL_LSB + scm_pkg::CHAN_W;
    localparam int PAD_W   = scm_pkg::OUT_TD_W - scm_pkg::CHAN_W - scm_pkg::OUT_VAL_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Field views of the input item
    logic signed [SAMPLE_BITS-1:0] w_sample;
    scm_pkg::t_chan                w_row;
    scm_pkg::t_chan                w_col;
    scm_pkg::t_coef                w_coef;

    // Control registers
    logic [scm_pkg::CFG_W-1:0] r_num_in;
    logic [scm_pkg::CFG_W-1:0] r_num_out;
    logic [1:0]                r_state,  n_state;
    logic [STEP_W-1:0]         r_step,   n_step;
    logic [IN_W-1:0]           r_in_cnt, n_in_cnt;
    logic [IN_W-1:0]           r_col,    n_col;
    logic                      r_final,  n_final;
    logic [NO_W-1:0]           r_nout,   n_nout;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    // Output stage
    logic                        r_out_vld, n_out_vld;
    scm_pkg::t_chan              r_out_chan;
    logic [scm_pkg::OUT_VAL_W-1:0] r_out_val;
    logic                        r_out_last;

    // Datapath wires
    logic [NI_W-1:0]          w_nin;
    logic [NO_W-1:0]          w_nout;
    logic                     w_accept;
    logic                     w_last_ch;
    logic                     w_coef_ok;
    logic                     w_adv;
    logic                     w_load;
    logic                     w_emit_shift;
    logic                     w_shift;
    scm_pkg::t_mac_ctl        w_ctl;
    scm_pkg::t_coef           w_weight;
    logic                     w_mac_vld;
    logic signed [ACC_W-1:0]  w_mac_sum;
    logic signed [ACC_W-1:0]  w_tail;
    logic signed [ACC_W-1:0]  w_acc [0:MAX_OUT_CHANNELS-1];
    logic signed [ACC_W-1:0]  w_shifted;
    logic [scm_pkg::OUT_VAL_W-1:0] w_sat;
    logic                     w_in_range;

    assign w_sample = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_row    = s_axis_tdata[COL_LSB-1:ROW_LSB];
    assign w_col    = s_axis_tdata[CF_LSB-1:COL_LSB];
    assign w_coef   = s_axis_tdata[CF_LSB+scm_pkg::COEF_W-1:CF_LSB];

    // Effective channel counts: zero acts as one, clamp to the maximum
    always_comb begin
        if (r_num_in == '0) begin
            w_nin = NI_W'(1);
        end else if (32'(r_num_in) > MAX_IN_CHANNELS) begin
            w_nin = NI_W'(MAX_IN_CHANNELS);
        end else begin
            w_nin = NI_W'(r_num_in);
        end
        if (r_num_out == '0) begin
            w_nout = NO_W'(1);
        end else if (32'(r_num_out) > MAX_OUT_CHANNELS) begin
            w_nout = NO_W'(MAX_OUT_CHANNELS);
        end else begin
            w_nout = NO_W'(r_num_out);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_in  <= scm_pkg::CFG_W'(1);
            r_num_out <= scm_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scm_pkg::REG_NUM_INPUTS:  r_num_in  <= i_cfg_data;
                scm_pkg::REG_NUM_OUTPUTS: r_num_out <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_last_ch     = (32'(r_in_cnt) >= 32'(w_nin) - 1);
    assign w_coef_ok     = (32'(w_row) < 32'(w_nout)) && (32'(w_col) < 32'(w_nin));

    // Emission advances when the output stage is free or being drained
    assign w_adv        = !r_out_vld || m_axis_tready;
    assign w_emit_shift = (r_state == ST_EMIT) && w_adv;
    assign w_load       = w_emit_shift && (32'(r_step) < 32'(r_nout));
    assign w_shift      = w_mac_vld || w_emit_shift;
    assign w_tail       = (r_state == ST_EMIT) ? '0 : w_mac_sum;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_in_cnt = r_in_cnt;
        n_col    = r_col;
        n_final  = r_final;
        n_nout   = r_nout;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (s_axis_tuser == scm_pkg::OPC_SAMPLE)) begin
                    n_state = ST_MAC;
                    n_step  = '0;
                    n_nout  = w_nout;
                    n_final = w_last_ch;
                    if (w_last_ch) begin
                        n_col    = IN_W'(w_nin - NI_W'(1));
                        n_in_cnt = '0;
                    end else begin
                        n_col    = r_in_cnt;
                        n_in_cnt = r_in_cnt + IN_W'(1);
                    end
                end
            end
            ST_MAC: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MAX_OUT_CHANNELS + 1)) begin
                    n_step  = '0;
                    n_state = r_final ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_adv) begin
                    n_step = r_step + STEP_W'(1);
                    if (r_step == STEP_W'(MAX_OUT_CHANNELS - 1)) begin
                        n_step  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_in_cnt <= '0;
            r_col    <= '0;
            r_final  <= 1'b0;
            r_nout   <= NO_W'(1);
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_in_cnt <= n_in_cnt;
            r_col    <= n_col;
            r_final  <= n_final;
            r_nout   <= n_nout;
        end
    end

    // Hold the sample for the whole rotation
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= w_sample;
        end
    end

    // Issue one weight read per ring step
    assign w_ctl.vld  = (r_state == ST_MAC) && (32'(r_step) < MAX_OUT_CHANNELS);
    assign w_ctl.gate = w_ctl.vld && (32'(r_step) < 32'(r_nout));

    scm_wmem #(
        .AW (AW)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_we    (w_accept && (s_axis_tuser == scm_pkg::OPC_COEF) && w_coef_ok),
        .i_waddr ({OUT_W'(w_row), IN_W'(w_col)}),
        .i_wdata (w_coef),
        .i_raddr ({OUT_W'(r_step), r_col}),
        .o_rdata (w_weight)
    );

    scm_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_weight (w_weight),
        .i_sample (r_sample),
        .i_acc    (w_acc[0]),
        .o_vld    (w_mac_vld),
        .o_sum    (w_mac_sum)
    );

    // Accumulator ring: cell 0 is the head, the tail takes the MAC sum (zero while emitting)
    for (genvar k = 0; k < MAX_OUT_CHANNELS; k++) begin : g_ring
        if (k == MAX_OUT_CHANNELS - 1) begin : g_tail
            scm_cell #(.ACC_W(ACC_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_tail),
                .o_q     (w_acc[k])
            );
        end else begin : g_body
            scm_cell #(.ACC_W(ACC_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_acc[k+1]),
                .o_q     (w_acc[k])
            );
        end
    end

    // Scale the head sum down and saturate to 32 bits
    assign w_shifted  = w_acc[0] >>> COEF_FRAC_BITS;
    assign w_in_range = (&w_shifted[ACC_W-1:scm_pkg::OUT_VAL_W-1]) ||
                        !(|w_shifted[ACC_W-1:scm_pkg::OUT_VAL_W-1]);
    assign w_sat = w_in_range ? w_shifted[scm_pkg::OUT_VAL_W-1:0] :
                   (w_shifted[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);

    // Output stage
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_chan <= scm_pkg::CHAN_W'(r_step);
            r_out_val  <= w_sat;
            r_out_last <= (32'(r_step) == 32'(r_nout) - 1);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_val, r_out_chan};
    assign m_axis_tlast  = r_out_last;

endmodule

// File: rtl/scm_wmem.sv
// Weight table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module scm_wmem #(
    parameter int AW = 10
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  scm_pkg::t_coef       i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output scm_pkg::t_coef       o_rdata
);

    localparam int DEPTH = 1 << AW;

    scm_pkg::t_coef r_mem [0:DEPTH-1];
    scm_pkg::t_coef r_rdata;

    // Write a weight
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one weight a cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/scm_mac.sv
// Shared multiply-accumulate unit that feeds the tail of the accumulator ring.
`timescale 1ns / 1ps
module scm_mac #(
    parameter int SAMPLE_BITS = 24,
    parameter int ACC_W       = 46
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scm_pkg::t_mac_ctl             i_ctl,
    input  scm_pkg::t_coef                i_weight,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [ACC_W-1:0]       i_acc,
    output logic                          o_vld,
    output logic signed [ACC_W-1:0]       o_sum
);

    localparam int PROD_W = SAMPLE_BITS + scm_pkg::COEF_W;

    scm_pkg::t_mac_ctl         r_ctl;
    logic                      r_vld;
    logic signed [PROD_W-1:0]  r_prod;

    // Align the token with the registered weight, then with the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_vld <= 1'b0;
        end else begin
            r_ctl <= i_ctl;
            r_vld <= r_ctl.vld;
        end
    end

    // Register the product; a closed gate gives zero
    always_ff @(posedge i_clk) begin
        if (r_ctl.gate) begin
            r_prod <= i_weight * i_sample;
        end else begin
            r_prod <= '0;
        end
    end

    assign o_vld = r_vld;
    assign o_sum = i_acc + ACC_W'(r_prod);

endmodule

// File: rtl/scm_cell.sv
// One accumulator cell of the rotating ring.
`timescale 1ns / 1ps
module scm_cell #(
    parameter int ACC_W = 46
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic signed [ACC_W-1:0] i_d,
    output logic signed [ACC_W-1:0] o_q
);

    logic signed [ACC_W-1:0] r_acc;

    // Take the neighbor's sum on each ring step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_shift) begin
            r_acc <= i_d;
        end
    end

    assign o_q = r_acc;

endmodule

// File: rtl/scm_checker.sv
// Port-level checker for the spatial channel mixer, bound to the top level.
`timescale 1ns / 1ps
module scm_port_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    // out_channel, out_value
    input logic [scm_pkg::OUT_TD_W-1:0]          m_axis_tdata,
    input logic                                  m_axis_tlast
);

    scm_pkg::t_chan r_exp_chan;
    logic           w_out_take;

    assign w_out_take = m_axis_tvalid && m_axis_tready;

    // Track the channel expected next within a time sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_chan <= '0;
        end else if (w_out_take) begin
            r_exp_chan <= m_axis_tlast ? '0 :
                          m_axis_tdata[scm_pkg::CHAN_W-1:0] + scm_pkg::CHAN_W'(1);
        end
    end

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Channels come out in order from zero, restarting after last
    a_chan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take |-> m_axis_tdata[scm_pkg::CHAN_W-1:0] == r_exp_chan)
        else $error("output channel out of sequence");

    // A last result that is not the first of its sample never carries channel zero
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take && m_axis_tlast && r_exp_chan != '0 |->
            m_axis_tdata[scm_pkg::CHAN_W-1:0] != '0)
        else $error("last result on a wrapped channel index");

endmodule

bind spatial_channel_mixer scm_port_checker u_scm_port_checker (.*);

// File: test/scm_checker.sv
// Checker of the spatial channel mixer: predicts every result transaction and compares.
`timescale 1ns / 1ps
module scm_checker #(
    parameter int IN_TD_W = 56
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [scm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // sample_value, coef_row, coef_col, coef_value
    input  logic [IN_TD_W-1:0]            s_axis_tdata,
    // opcode
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_channel, out_value
    input  logic [scm_pkg::OUT_TD_W-1:0]  m_axis_tdata,
    input  logic                          m_axis_tlast,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count
);
    import scm_pkg::*;

    localparam int MAX_IN_CHANNELS  = 32;
    localparam int MAX_OUT_CHANNELS = 32;
    localparam int SAMPLE_BITS      = 24;
    localparam int COEF_FRAC_BITS   = 14;
    localparam int REPORT_LIMIT     = 10;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    typedef struct packed {
        t_chan              chan;
        logic signed [31:0] value;
        logic               is_last;
    } mix_out_t;

    // Mirror of the block: weight table, per-channel sums, next input channel, sizes
    t_coef              weight_mem [MAX_OUT_CHANNELS][MAX_IN_CHANNELS];
    logic signed [63:0] chan_sum   [MAX_OUT_CHANNELS];
    int                 next_in_chan = 0;
    logic [CFG_W-1:0]   size_in      = 1;
    logic [CFG_W-1:0]   size_out     = 1;
    mix_out_t           mixed_q [$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
    end

    // A size of zero acts as one; anything above the maximum acts as the maximum
    function automatic int active_count(input logic [CFG_W-1:0] r, input int ceiling);
        if (r == 0) return 1;
        if (r > ceiling) return ceiling;
        return int'(r);
    endfunction

    // Apply one input transaction; queue the results of a completed time instant
    task automatic mix_item(input logic op, input logic signed [SAMPLE_BITS-1:0] smp,
                            input t_chan row, input t_chan col, input t_coef cv);
        int                 n_in;
        int                 n_out;
        int                 c;
        int                 j;
        logic               closes;
        logic signed [63:0] w64;
        logic signed [63:0] s64;
        logic signed [63:0] v;
        mix_out_t           res;
        n_in  = active_count(size_in, MAX_IN_CHANNELS);
        n_out = active_count(size_out, MAX_OUT_CHANNELS);
        if (op == OPC_COEF) begin
            if (row < n_out && col < n_in) weight_mem[row][col] = cv;
            return;
        end
        // clamp the column when the count already reached the last channel
        c      = next_in_chan;
        closes = 1'b0;
        if (c >= n_in - 1) begin
            c      = n_in - 1;
            closes = 1'b1;
        end
        s64 = smp;
        for (j = 0; j < n_out; j++) begin
            w64         = weight_mem[j][c];
            chan_sum[j] = chan_sum[j] + w64 * s64;
        end
        if (!closes) begin
            next_in_chan = c + 1;
            return;
        end
        // emit one result per output channel, floor shift and saturate
        for (j = 0; j < n_out; j++) begin
            v = chan_sum[j] >>> COEF_FRAC_BITS;
            if (v > SAT_HI) res.value = SAT_HI[31:0];
            else if (v < SAT_LO) res.value = SAT_LO[31:0];
            else res.value = v[31:0];
            res.chan    = t_chan'(j);
            res.is_last = (j == n_out - 1);
            mixed_q.push_back(res);
        end
        for (j = 0; j < MAX_OUT_CHANNELS; j++) chan_sum[j] = '0;
        next_in_chan = 0;
    endtask

    // Compare one result transaction with the oldest prediction
    task automatic check_result(input mix_out_t got);
        mix_out_t want;
        o_result_count++;
        if (mixed_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT)
                $display("unexpected result: channel %0d value %0d last %0b",
                         got.chan, got.value, got.is_last);
            return;
        end
        want = mixed_q.pop_front();
        if (got.chan !== want.chan || got.value !== want.value ||
            got.is_last !== want.is_last) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT)
                $display("mismatch: channel exp %0d got %0d, value exp %0d got %0d, last exp %0b got %0b",
                         want.chan, got.chan, want.value, got.value, want.is_last, got.is_last);
        end
    endtask

    // Watch all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mixed_q.delete();
            for (int j = 0; j < MAX_OUT_CHANNELS; j++) chan_sum[j] = '0;
            next_in_chan = 0;
            size_in      = 1;
            size_out     = 1;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result('{chan: m_axis_tdata[CHAN_W-1:0],
                               value: m_axis_tdata[CHAN_W+OUT_VAL_W-1:CHAN_W],
                               is_last: m_axis_tlast});
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NUM_INPUTS:  size_in  = i_cfg_data;
                    REG_NUM_OUTPUTS: size_out = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                mix_item(s_axis_tuser,
                         s_axis_tdata[SAMPLE_BITS-1:0],
                         s_axis_tdata[SAMPLE_BITS+CHAN_W-1:SAMPLE_BITS],
                         s_axis_tdata[SAMPLE_BITS+2*CHAN_W-1:SAMPLE_BITS+CHAN_W],
                         s_axis_tdata[SAMPLE_BITS+2*CHAN_W+COEF_W-1:SAMPLE_BITS+2*CHAN_W]);
        end
        o_pending = mixed_q.size();
    end

endmodule

// File: test/tb_top.sv
// Testbench top of the spatial channel mixer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import scm_pkg::*;

    localparam int MAX_IN_CHANNELS  = 32;
    localparam int MAX_OUT_CHANNELS = 32;
    localparam int SAMPLE_BITS      = 24;
    localparam int IN_TD_W          = ((SAMPLE_BITS + 2 * CHAN_W + COEF_W + 7) / 8) * 8;
    localparam int ITEM_TARGET      = 460;
    localparam int DRAIN_CYCLES     = 2 * (MAX_OUT_CHANNELS + 3) + 8;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = REG_NUM_INPUTS;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_TD_W-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tuser  = OPC_SAMPLE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_TD_W-1:0]  m_axis_tdata;
    logic                 m_axis_tlast;

    int fail_count;
    int pending;
    int result_count;

    // Stimulus-side view of sizes and of which weights hold a value
    int   nin_now      = 1;
    int   nout_now     = 1;
    logic coef_set [MAX_OUT_CHANNELS][MAX_IN_CHANNELS];
    logic tx_steady    = 1'b0;
    int   burst_left   = 0;
    int   samples_sent = 0;
    int   items_sent   = 0;
    int   reg_writes   = 0;
    int   rx_tick      = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    spatial_channel_mixer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    scm_checker #(.IN_TD_W(IN_TD_W)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Stall the result side, cycling through its own set of patterns
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case ((rx_tick / 256) % 4)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= ((rx_tick % 11) < 3);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2:       return 24'h00_0000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_coef rand_coef();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Send one input transaction; gaps fall between bursts unless the sender is steady
    task automatic push_item(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                             input t_chan row, input t_chan col, input t_coef cv);
        int gap;
        if (!tx_steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        s_axis_tdata  <= IN_TD_W'({cv, col, row, smp});
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        if (op == OPC_COEF && row < nout_now && col < nin_now) coef_set[row][col] = 1'b1;
    endtask

    // Hold the sender until every result is in and the block has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        int eff;
        settle();
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_writes++;
        eff = (val == 0) ? 1 : ((val > MAX_IN_CHANNELS) ? MAX_IN_CHANNELS : int'(val));
        if (idx == REG_NUM_INPUTS) nin_now = eff;
        else nout_now = eff;
    endtask

    // Write every weight the current sizes can read that holds no value yet
    task automatic fill_weights();
        for (int r = 0; r < nout_now; r++)
            for (int c = 0; c < nin_now; c++)
                if (!coef_set[r][c])
                    push_item(OPC_COEF, SAMPLE_BITS'($urandom), t_chan'(r), t_chan'(c),
                              rand_coef());
    endtask

    // One full time instant with stray coefficient writes mixed in
    task automatic mix_instant();
        fill_weights();
        for (int k = 0; k < nin_now; k++) begin
            if ($urandom_range(0, 9) == 0)
                push_item(OPC_COEF, SAMPLE_BITS'($urandom), CHAN_W'($urandom),
                          CHAN_W'($urandom), rand_coef());
            push_item(OPC_SAMPLE, rand_sample(), CHAN_W'($urandom), CHAN_W'($urandom),
                      COEF_W'($urandom));
            samples_sent++;
        end
    endtask

    initial begin : stimulus
        int reps;
        int want_in;
        int want_out;
        for (int r = 0; r < MAX_OUT_CHANNELS; r++)
            for (int c = 0; c < MAX_IN_CHANNELS; c++)
                coef_set[r][c] = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sizes after reset: one weight at negative full scale, out-of-range writes dropped
        push_item(OPC_COEF, 24'h0, 5'd0, 5'd0, 16'h8000);
        push_item(OPC_COEF, 24'h0, 5'd1, 5'd0, 16'h7FFF);
        push_item(OPC_COEF, 24'h0, 5'd0, 5'd1, 16'h7FFF);
        push_item(OPC_SAMPLE, 24'h7F_FFFF, 5'd0, 5'd0, 16'h0);
        push_item(OPC_SAMPLE, 24'h80_0000, 5'd0, 5'd0, 16'h0);
        samples_sent += 2;

        // Three inputs, four outputs with full-scale rows and a weight change mid-instant
        write_reg(REG_NUM_INPUTS, 6'd3);
        write_reg(REG_NUM_OUTPUTS, 6'd4);
        for (int c = 0; c < 3; c++) begin
            push_item(OPC_COEF, 24'h0, 5'd0, t_chan'(c), 16'h7FFF);
            push_item(OPC_COEF, 24'h0, 5'd1, t_chan'(c), 16'h8000);
        end
        fill_weights();
        push_item(OPC_SAMPLE, 24'h7F_FFFF, 5'd0, 5'd0, 16'h0);
        push_item(OPC_SAMPLE, 24'h80_0000, 5'd0, 5'd0, 16'h0);
        push_item(OPC_COEF, 24'h0, 5'd2, 5'd2, 16'h4000);
        push_item(OPC_SAMPLE, 24'h7F_FFFF, 5'd0, 5'd0, 16'h0);

        // Shrink both sizes mid-instant: the next sample closes the instant
        push_item(OPC_SAMPLE, 24'h12_3456, 5'd0, 5'd0, 16'h0);
        push_item(OPC_SAMPLE, 24'hFE_DCBA, 5'd0, 5'd0, 16'h0);
        write_reg(REG_NUM_OUTPUTS, 6'd2);
        write_reg(REG_NUM_INPUTS, 6'd2);
        push_item(OPC_SAMPLE, 24'h80_0000, 5'd0, 5'd0, 16'h0);
        samples_sent += 6;

        // Register values below and above the legal range
        write_reg(REG_NUM_INPUTS, 6'd0);
        write_reg(REG_NUM_OUTPUTS, 6'd63);
        mix_instant();
        write_reg(REG_NUM_INPUTS, 6'd63);
        write_reg(REG_NUM_OUTPUTS, 6'd0);
        mix_instant();

        // Random phases: mostly small sizes, now and then one wide side
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0: begin want_in = $urandom_range(9, 32); want_out = 2; end
                1: begin want_in = 1;  want_out = 1;  end
                2: begin want_in = 1;  want_out = 32; end
                3: begin want_in = 32; want_out = 1;  end
                4: begin
                    want_in  = ($urandom_range(0, 1) == 1) ? $urandom_range(33, 63) : 0;
                    want_out = $urandom_range(0, 3);
                end
                default: begin
                    want_in  = $urandom_range(1, 8);
                    want_out = $urandom_range(1, 8);
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_NUM_INPUTS, CFG_W'(want_in));
                write_reg(REG_NUM_OUTPUTS, CFG_W'(want_out));
            end else begin
                write_reg(REG_NUM_OUTPUTS, CFG_W'(want_out));
                write_reg(REG_NUM_INPUTS, CFG_W'(want_in));
            end
            tx_steady = ($urandom_range(0, 3) == 0);
            reps = (nin_now > 8) ? $urandom_range(1, 2) : $urandom_range(2, 8);
            for (int r = 0; r < reps && items_sent < ITEM_TARGET; r++) begin
                mix_instant();
                if ($urandom_range(0, 7) == 0) settle();
            end
        end

        settle();
        $display("Sent %0d input transactions (%0d samples), got %0d result transactions",
                 items_sent, samples_sent, result_count);
        $display("over %0d register writes; covered full-scale data, dropped weight writes,",
                 reg_writes);
        $display("clamped sizes and a mid-instant resize");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
